/* hw/rtl/blum_pkg.sv */
package blum_pkg;

  localparam int VALUE_BITS_DEF = 20;
  localparam int CFG_W          = 21;
  localparam int SMALL_W        = 10;
  localparam int LARGE_W        = 19;

  localparam logic [CFG_W-1:0] LIMIT_RESET = 21'h100000;

  // first odd trial divisor and the residue mod 4 that a Blum prime needs
  localparam int         FIRST_DIV  = 3;
  localparam logic [1:0] BLUM_RES   = 2'b11;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FCHK,
    S_FDIV,
    S_PCHK,
    S_PDIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_stat_t;

endpackage

/* hw/rtl/blum_div.sv */
module blum_div #(
  parameter int VALUE_BITS = blum_pkg::VALUE_BITS_DEF,
  parameter int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [VALUE_BITS-1:0]   dividend,
  input  logic [DIV_BITS-1:0]     divisor,
  output logic [VALUE_BITS-1:0]   quotient,
  output blum_pkg::div_stat_t     stat
);

  localparam int CW = $clog2(VALUE_BITS + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [DIV_BITS-1:0]   rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] quo_r, quo_nxt;

  logic [DIV_BITS:0]     trial;
  logic [DIV_BITS:0]     diff;
  logic                  ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_r, quo_r[VALUE_BITS-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    done_nxt = busy_r && !start && (cnt_r == CW'(1));
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(VALUE_BITS);
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
      quo_nxt = {quo_r[VALUE_BITS-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient      = quo_r;
  assign stat.done     = done_r;
  assign stat.rem_zero = (rem_r == '0);

endmodule

/* hw/rtl/blum_integer_test_unit.sv */
// Blum integer test.
// Input channel (in_valid / in_stall / in_value): one word per value to test.
// Output channel (out_valid / out_stall / out_is_blum, out_small_factor,
// out_large_factor): exactly one word per input word, in order. Factors are
// zero when the value is not a product of two distinct primes = 3 mod 4 that
// lies below the limit.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes the upper limit;
// always ready. Write it only while the block is idle.
// One shared restoring divider does every trial division; each odd trial
// divisor passes through a check and issue state and then a divide state.
// An item that is rejected up front (even, below 2, at or above limit) goes
// straight to the finish state; otherwise the trials run from 3 up to
// sqrt(value) for the factor search and then up to sqrt(q) for the
// primality test of the cofactor. in_stall is high from acceptance until
// the result is moved into the output register.
// The output register holds one result; a stalled receiver keeps it and the
// next item may be accepted and worked on meanwhile. Reset clears the
// sequencer and output valid and sets the limit to 2^20.
module blum_integer_test_unit #(
  parameter int VALUE_BITS = blum_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [VALUE_BITS-1:0]         in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_blum,
  output logic [blum_pkg::SMALL_W-1:0]  out_small_factor,
  output logic [blum_pkg::LARGE_W-1:0]  out_large_factor,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [blum_pkg::CFG_W-1:0]    cfg_data
);

  localparam int DW = (VALUE_BITS + 1) / 2 + 1;
  localparam int SW = 2 * DW;
  localparam int LW = (VALUE_BITS > blum_pkg::CFG_W) ? VALUE_BITS : blum_pkg::CFG_W;
  localparam int FIRST_SQ = blum_pkg::FIRST_DIV * blum_pkg::FIRST_DIV;

  blum_pkg::state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0]        n_r, n_nxt;
  logic [DW-1:0]                d_r, d_nxt;
  logic [SW-1:0]                sq_r, sq_nxt;
  logic [DW-1:0]                p_r, p_nxt;
  logic                         ok_r, ok_nxt;
  logic [blum_pkg::CFG_W-1:0]   limit_r, limit_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_blum_r, out_blum_nxt;
  logic [blum_pkg::SMALL_W-1:0] out_small_r, out_small_nxt;
  logic [blum_pkg::LARGE_W-1:0] out_large_r, out_large_nxt;

  logic                         div_start;
  logic [VALUE_BITS-1:0]        quo;
  blum_pkg::div_stat_t          div_stat;

  logic accept;
  logic in_ok;
  logic sq_over;
  logic out_free;
  logic pair_ok;

  blum_div #(
    .VALUE_BITS (VALUE_BITS),
    .DIV_BITS   (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_r),
    .divisor  (d_r),
    .quotient (quo),
    .stat     (div_stat)
  );

  assign accept   = in_valid && !in_stall;
  // even values and values below 2 cannot be a product of two odd primes
  assign in_ok    = (LW'(in_value) < LW'(limit_r)) && in_value[0]
                    && (in_value != VALUE_BITS'(1));
  assign sq_over  = sq_r > SW'(n_r);
  assign out_free = !out_valid_r || !out_stall;
  assign pair_ok  = (d_r[1:0] == blum_pkg::BLUM_RES) && (quo[1:0] == blum_pkg::BLUM_RES)
                    && (VALUE_BITS'(d_r) != quo);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      blum_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_ok ? blum_pkg::S_FCHK : blum_pkg::S_FIN;
        end
      end
      blum_pkg::S_FCHK: begin
        state_nxt = sq_over ? blum_pkg::S_FIN : blum_pkg::S_FDIV;
      end
      blum_pkg::S_FDIV: begin
        if (div_stat.done) begin
          if (div_stat.rem_zero) begin
            state_nxt = pair_ok ? blum_pkg::S_PCHK : blum_pkg::S_FIN;
          end else begin
            state_nxt = blum_pkg::S_FCHK;
          end
        end
      end
      blum_pkg::S_PCHK: begin
        state_nxt = sq_over ? blum_pkg::S_FIN : blum_pkg::S_PDIV;
      end
      blum_pkg::S_PDIV: begin
        if (div_stat.done) begin
          state_nxt = div_stat.rem_zero ? blum_pkg::S_FIN : blum_pkg::S_PCHK;
        end
      end
      blum_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = blum_pkg::S_IDLE;
        end
      end
      default: state_nxt = blum_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = (state_r != blum_pkg::S_IDLE);
    div_start = 1'b0;
    unique case (state_r)
      blum_pkg::S_FCHK,
      blum_pkg::S_PCHK: div_start = !sq_over;
      default:          div_start = 1'b0;
    endcase
  end

  // datapath
  always_comb begin
    n_nxt         = n_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    p_nxt         = p_r;
    ok_nxt        = ok_r;
    limit_nxt     = limit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_blum_nxt  = out_blum_r;
    out_small_nxt = out_small_r;
    out_large_nxt = out_large_r;

    if (cfg_valid && cfg_ready) begin
      limit_nxt = cfg_data;
    end

    if (accept) begin
      n_nxt  = in_value;
      d_nxt  = DW'(blum_pkg::FIRST_DIV);
      sq_nxt = SW'(FIRST_SQ);
      ok_nxt = 1'b0;
    end

    if (div_stat.done && (state_r == blum_pkg::S_FDIV || state_r == blum_pkg::S_PDIV)) begin
      if (div_stat.rem_zero) begin
        if (state_r == blum_pkg::S_FDIV) begin
          // keep d and its square: the cofactor has no divisor below p
          p_nxt = d_r;
          n_nxt = quo;
        end
      end else begin
        // advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4
        d_nxt  = d_r + DW'(2);
        sq_nxt = sq_r + SW'({d_r, 2'b00}) + SW'(4);
      end
    end

    if (state_r == blum_pkg::S_PCHK && sq_over) begin
      ok_nxt = 1'b1;
    end

    if (state_r == blum_pkg::S_FIN && out_free) begin
      out_valid_nxt = 1'b1;
      out_blum_nxt  = ok_r;
      out_small_nxt = ok_r ? blum_pkg::SMALL_W'(p_r) : '0;
      out_large_nxt = ok_r ? blum_pkg::LARGE_W'(n_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= blum_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      limit_r     <= blum_pkg::LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      limit_r     <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    p_r         <= p_nxt;
    ok_r        <= ok_nxt;
    out_blum_r  <= out_blum_nxt;
    out_small_r <= out_small_nxt;
    out_large_r <= out_large_nxt;
  end

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_is_blum      = out_blum_r;
  assign out_small_factor = out_small_r;
  assign out_large_factor = out_large_r;

  a_blum_factor_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_blum |-> out_small_factor[1:0] == blum_pkg::BLUM_RES
                                 && out_large_factor[1:0] == blum_pkg::BLUM_RES)
    else $error("Blum result with a factor not 3 mod 4");

  a_not_blum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_blum |-> out_small_factor == '0 && out_large_factor == '0)
    else $error("non-Blum result with nonzero factors");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == blum_pkg::S_FDIV || state_r == blum_pkg::S_PDIV)
    else $error("divider finished outside a divide state");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted word did not start work");

endmodule
